### hw/rtl/dfd_pkg.sv
// shared types, constants and codes for the error diffusion dither block
`default_nettype none

package dfd_pkg;

    // default sizing
    localparam int DFD_MAX_WIDTH     = 1024;
    localparam int DFD_ACC_FRAC_BITS = 4;

    // configuration port
    localparam int DFD_CFG_IDX_W  = 2;
    localparam int DFD_CFG_DATA_W = 16;
    localparam int DFD_WIDTH_W    = 11;
    localparam int DFD_HEIGHT_W   = 16;

    localparam logic [DFD_WIDTH_W-1:0]  DFD_WIDTH_RST  = 11'd640;
    localparam logic [DFD_HEIGHT_W-1:0] DFD_HEIGHT_RST = 16'd480;

    typedef enum logic [DFD_CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_index_t;

    // input pixel
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    // dithered result
    typedef struct packed {
        logic red_bit;
        logic green_bit;
        logic blue_bit;
        logic frame_last;
    } result_t;

    // where a pixel sits in the frame
    typedef struct packed {
        logic first_row;
        logic has_left;
        logic has_right;
        logic has_below;
        logic last;
    } pos_t;

    // control from the sequencer to each channel lane
    typedef struct packed {
        logic rd_en;
        logic adv;
        logic clr;
        pos_t pos;
    } lane_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/dfd_ram.sv
// generic single write port ram with registered read
`default_nettype none

module dfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/dfd_lane.sv
// one color channel: threshold, error split and next-row error buffer
`default_nettype none

module dfd_lane
    import dfd_pkg::*;
#(
    parameter int MAX_WIDTH     = DFD_MAX_WIDTH,
    parameter int ACC_FRAC_BITS = DFD_ACC_FRAC_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire lane_ctl_t                    ctl,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] col,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] clr_addr,
    input  wire logic [7:0]                   pix,
    output logic                              pix_bit
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int ACC    = ACC_FRAC_BITS + 12;
    localparam int HALF_I = 255 * (2 ** (ACC_FRAC_BITS - 1));
    localparam int FULL_I = 255 * (2 ** ACC_FRAC_BITS);
    localparam logic signed [ACC-1:0] HALF    = ACC'(HALF_I);
    localparam logic signed [ACC-1:0] ACC_MAX = {1'b0, {(ACC-1){1'b1}}};
    localparam logic signed [ACC-1:0] ACC_MIN = {1'b1, {(ACC-1){1'b0}}};

    function automatic logic signed [ACC-1:0] sat(input logic signed [ACC:0] v);
        logic signed [ACC-1:0] r;
        if (v[ACC] != v[ACC-1])
        begin
            r = v[ACC] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            r = v[ACC-1:0];
        end
        return r;
    endfunction

    // carries and buffer bookkeeping
    logic signed [ACC-1:0] rc_reg, rc_next;
    logic signed [ACC-1:0] dc_reg, dc_next;
    logic signed [ACC-1:0] pend_reg, pend_next;
    logic [CW-1:0]         pend_addr_reg;
    logic                  pend_vld_reg;
    logic [CW-1:0]         lw_addr_reg;
    logic signed [ACC-1:0] lw_data_reg;
    logic                  lw_vld_reg;

    logic [ACC-1:0]        ram_q;
    logic                  wr_en;
    logic [CW-1:0]         wr_addr;
    logic signed [ACC-1:0] wr_data;

    logic signed [ACC-1:0] raw, below, rc_eff, dc_eff, t, val;
    logic                  bit_on;
    logic signed [ACC:0]   err;
    logic signed [ACC+3:0] e_w, p7, p5, p3;
    logic signed [ACC-1:0] s7, s5, s3, s1;
    logic                  fin;

    dfd_ram #(
        .WIDTH(ACC),
        .DEPTH(MAX_WIDTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (ctl.rd_en),
        .rd_addr(rd_addr),
        .rd_data(ram_q)
    );

    // newest copy of the entry under this column: unwritten pending, last write, ram
    always_comb
    begin
        if (pend_vld_reg && (pend_addr_reg == col))
        begin
            raw = pend_reg;
        end
        else if (lw_vld_reg && (lw_addr_reg == col))
        begin
            raw = lw_data_reg;
        end
        else
        begin
            raw = ram_q;
        end
    end

    // threshold and error split
    always_comb
    begin
        below  = ctl.pos.first_row ? '0 : raw;
        rc_eff = ctl.pos.has_left ? rc_reg : '0;
        dc_eff = ctl.pos.has_left ? dc_reg : '0;
        t      = sat($signed((ACC+1)'({pix, {ACC_FRAC_BITS{1'b0}}})) + (ACC+1)'(below));
        val    = sat((ACC+1)'(t) + (ACC+1)'(rc_eff));
        bit_on = val > HALF;
        err    = (ACC+1)'(val) - (bit_on ? (ACC+1)'(FULL_I) : (ACC+1)'(0));
        e_w    = (ACC+4)'(err);
        p7     = (e_w <<< 3) - e_w;
        p5     = (e_w <<< 2) + e_w;
        p3     = (e_w <<< 1) + e_w;
        s7     = p7[ACC+3:4];
        s5     = p5[ACC+3:4];
        s3     = p3[ACC+3:4];
        s1     = e_w[ACC+3:4];
    end

    assign pix_bit = bit_on;

    // carry and pending updates
    always_comb
    begin
        fin       = ctl.pos.has_below && ctl.pos.has_left;
        rc_next   = ctl.pos.has_right ? s7 : '0;
        dc_next   = (ctl.pos.has_below && ctl.pos.has_right) ? s1 : '0;
        pend_next = ctl.pos.has_below ? sat((ACC+1)'(dc_eff) + (ACC+1)'(s5)) : raw;
    end

    // one write per transfer: previous column, finished or as it stands
    always_comb
    begin
        if (ctl.clr)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr;
            wr_data = '0;
        end
        else
        begin
            wr_en   = ctl.adv && pend_vld_reg;
            wr_addr = pend_addr_reg;
            wr_data = fin ? sat((ACC+1)'(pend_reg) + (ACC+1)'(s3)) : pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg       <= '0;
            dc_reg       <= '0;
            pend_vld_reg <= 1'b0;
            lw_vld_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                pend_vld_reg <= 1'b0;
            end
            else if (ctl.adv)
            begin
                rc_reg       <= rc_next;
                dc_reg       <= dc_next;
                pend_vld_reg <= 1'b1;
            end
            if (wr_en)
            begin
                lw_vld_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.adv && !ctl.clr)
        begin
            pend_reg      <= pend_next;
            pend_addr_reg <= col;
        end
        if (wr_en)
        begin
            lw_addr_reg <= wr_addr;
            lw_data_reg <= wr_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/error_diffusion_dither.sv
// top level of the floyd-steinberg error diffusion dither
`default_nettype none

// Dithers an RGB stream, 8 bits per channel in raster order, to one bit per
// channel with Floyd-Steinberg error diffusion. One pixel is taken per clock
// and one result leaves per clock while no stall holds the flow; a result is
// registered in the pixel stage, then in the output register. The three
// channels run in separate lanes; in each, the 7/16 right carry is
// combinational (add, saturate, compare, split), which sets the
// one-pixel-per-clock pace, and each lane's next-row error buffer is a memory
// that sees one read and one write per pixel. After reset the buffers are
// swept to zero, one entry a cycle over all MAX_WIDTH entries, with in_stall
// high; configuration writes are taken meanwhile. Width and height are
// written on the configuration port (index 0 and 1), zero counts as one and
// width is capped at MAX_WIDTH; frame_last marks the last pixel of each frame.
module error_diffusion_dither
    import dfd_pkg::*;
#(
    parameter int MAX_WIDTH     = DFD_MAX_WIDTH,
    parameter int ACC_FRAC_BITS = DFD_ACC_FRAC_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire pixel_t                    in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output result_t                        out_data,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [DFD_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [DFD_CFG_DATA_W-1:0] cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > DFD_WIDTH_W) ? CW + 1 : DFD_WIDTH_W;

    logic [DFD_WIDTH_W-1:0]  width_reg;
    logic [DFD_HEIGHT_W-1:0] height_reg;
    logic [CW-1:0]           col_reg, col_next;
    logic [DFD_HEIGHT_W-1:0] row_reg, row_next;
    logic                    clr_busy_reg;
    logic [CW-1:0]           clr_addr_reg;

    logic                    s1_vld_reg, s1_vld_next;
    pixel_t                  s1_pix_reg;
    pos_t                    s1_pos_reg;
    logic [CW-1:0]           s1_col_reg;
    logic                    out_vld_reg;
    result_t                 out_data_reg;

    logic                    accept, s1_adv;
    logic [CMPW-1:0]         w_ext, w_eff;
    logic [DFD_HEIGHT_W-1:0] h_eff;
    logic                    last_col, last_row;
    pos_t                    pos_now;
    lane_ctl_t               ctl;
    logic [7:0]              lane_pix [3];
    logic                    lane_bit [3];

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DFD_WIDTH_RST;
            height_reg <= DFD_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[DFD_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[DFD_HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // handshake and pipeline advance
    assign s1_adv      = s1_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall    = clr_busy_reg || (s1_vld_reg && !s1_adv);
    assign accept      = in_valid && !in_stall;
    assign s1_vld_next = accept || (s1_vld_reg && !s1_adv);

    // position of the incoming pixel
    always_comb
    begin
        w_ext = CMPW'(width_reg);
        if (w_ext == '0)
        begin
            w_eff = CMPW'(1);
        end
        else if (w_ext > CMPW'(MAX_WIDTH))
        begin
            w_eff = CMPW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end
        h_eff    = (height_reg == '0) ? DFD_HEIGHT_W'(1) : height_reg;
        last_col = (CMPW'(col_reg) + CMPW'(1)) >= w_eff;
        last_row = ({1'b0, row_reg} + (DFD_HEIGHT_W+1)'(1)) >= {1'b0, h_eff};

        pos_now.first_row = (row_reg == '0);
        pos_now.has_left  = (col_reg != '0);
        pos_now.has_right = !last_col;
        pos_now.has_below = !last_row;
        pos_now.last      = last_col && last_row;

        col_next = last_col ? '0 : col_reg + CW'(1);
        if (!last_col)
        begin
            row_next = row_reg;
        end
        else if (last_row)
        begin
            row_next = '0;
        end
        else
        begin
            row_next = row_reg + DFD_HEIGHT_W'(1);
        end
    end

    // column and row counters, buffer sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + CW'(1);
                if (clr_addr_reg == CW'(MAX_WIDTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            s1_vld_reg <= s1_vld_next;
            if (s1_adv)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // pixel stage and output register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= in_data;
            s1_pos_reg <= pos_now;
            s1_col_reg <= col_reg;
        end
        if (s1_adv)
        begin
            out_data_reg.red_bit    <= lane_bit[0];
            out_data_reg.green_bit  <= lane_bit[1];
            out_data_reg.blue_bit   <= lane_bit[2];
            out_data_reg.frame_last <= s1_pos_reg.last;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    // lane control
    always_comb
    begin
        ctl.rd_en = accept;
        ctl.adv   = s1_adv;
        ctl.clr   = clr_busy_reg;
        ctl.pos   = s1_pos_reg;
    end

    assign lane_pix[0] = s1_pix_reg.red_in;
    assign lane_pix[1] = s1_pix_reg.green_in;
    assign lane_pix[2] = s1_pix_reg.blue_in;

    // one lane per color channel
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        dfd_lane #(
            .MAX_WIDTH    (MAX_WIDTH),
            .ACC_FRAC_BITS(ACC_FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .rd_addr (col_reg),
            .col     (s1_col_reg),
            .clr_addr(clr_addr_reg),
            .pix     (lane_pix[i]),
            .pix_bit (lane_bit[i])
        );
    end

endmodule

`default_nettype wire

### hw/rtl/dfd_checker.sv
// port-level checks for the error diffusion dither, bound to the top level
`default_nettype none

module dfd_checker
    import dfd_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    in_valid,
    input wire logic    in_stall,
    input wire logic    out_valid,
    input wire logic    out_stall,
    input wire result_t out_data
);

    // a held result keeps its valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

    // a pixel taken with the output empty reaches it via s1 and output reg
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |-> ##2 out_valid)
    else $error("result missing two cycles after transfer");

    // once the sweep is over, an empty output never holds back the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && $past(!in_stall) |-> !in_stall)
    else $error("input stalled with free output");

endmodule

bind error_diffusion_dither dfd_checker u_dfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);

`default_nettype wire
